### hw/rtl/dtls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtls_pkg
// Types, field widths and codes for the takeoff and landing sequencer.
// ----------------------------------------------------------------------------
package dtls_pkg;

   // Width of the microsecond timestamp
   localparam int TimeBits      = 48;
   localparam int ReqDataBits   = 104;
   localparam int RspDataBits   = 16;
   localparam int CsrIndexBits  = 3;
   localparam int CsrDataBits   = 17;
   localparam int TimeoutSecBits = 16;
   localparam int UsPerSecBits  = 20;
   localparam int TimeoutUsBits = TimeoutSecBits + UsPerSecBits;
   localparam int AltBits       = 24;
   localparam int AltCfgBits    = 17;

   localparam logic [UsPerSecBits-1:0] UsPerSec = 20'd1000000;

   typedef enum logic [3:0] {
      ST_STANDBY   = 4'd0,
      ST_TO_REQ    = 4'd1,
      ST_TO_READY  = 4'd2,
      ST_AIRBORNE  = 4'd3,
      ST_LD_REQ    = 4'd4,
      ST_LANDING   = 4'd5,
      ST_TOUCHDOWN = 4'd6,
      ST_LANDED    = 4'd7,
      ST_RECOVER   = 4'd8
   } mission_state_type;

   typedef enum logic [1:0] {
      KIND_TICK           = 2'd0,
      KIND_TAKEOFF_READY  = 2'd1,
      KIND_LANDING_READY  = 2'd2,
      KIND_BOX_STATE      = 2'd3
   } item_kind_type;

   localparam logic [4:0] MODE_NONE      = 5'd0;
   localparam logic [4:0] MODE_STABILIZE = 5'd0;
   localparam logic [4:0] MODE_ALT_HOLD  = 5'd2;
   localparam logic [4:0] MODE_AUTO      = 5'd3;
   localparam logic [4:0] MODE_GUIDED    = 5'd4;
   localparam logic [4:0] MODE_LOITER    = 5'd5;
   localparam logic [4:0] MODE_RTL       = 5'd6;
   localparam logic [4:0] MODE_LAND      = 5'd9;

   localparam logic [3:0] FIX_RTK = 4'd6;

   localparam logic [1:0] BOX_OTHER    = 2'd0;
   localparam logic [1:0] BOX_STANDBY  = 2'd1;
   localparam logic [1:0] BOX_AIRBORNE = 2'd2;
   localparam logic [1:0] BOX_LANDED   = 2'd3;

   localparam logic [CsrIndexBits-1:0] REG_GPS_TIMEOUT  = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_GPS_HACC_MAX = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_AUTO_ARM     = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_TAKEOFF_ALT  = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_LAND_ALT     = 3'd4;

   localparam logic [TimeoutUsBits-1:0] TimeoutUsReset = 36'd100000000;
   localparam logic [15:0]              HaccMaxReset   = 16'd1000;
   localparam logic [AltCfgBits-1:0]    TakeoffAltReset = 17'd2000;
   localparam logic [AltCfgBits-1:0]    LandAltReset    = 17'd2000;

endpackage

### hw/rtl/drone_takeoff_landing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drone_takeoff_landing_sequencer
// Nine-state takeoff and landing mission machine for a box-based drone.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the result side is not stalled, and
// its single result is presented from the result register. The item is
// captured in an input register. The mission logic (mode override, GPS
// wait with timeout and the altitude compares) then runs in one pass. Its
// outcome lands in the result register together with the updated mission
// state. The GPS timeout in microseconds is formed by a multiply when the
// timeout register is written, so the per-item path holds only a 48-bit
// subtract and compare. A stalled result holds the item in the input
// register and drops req_tready until the result register drains. While
// the input register is empty, it still takes one item.
module drone_takeoff_landing_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   // flight_mode[4:0], armed[5], altitude_cm[29:6], gps_fix[33:30],
   // gps_hacc_mm[49:34], now_us[97:50], ready_req[98], box_code[100:99]
   input  logic [dtls_pkg::ReqDataBits-1:0]      req_tdata,
   // kind[1:0]
   input  logic [1:0]                            req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // mission_code[3:0], mode_request_valid[4], mode_request[9:5],
   // arm_request[10]
   output logic [dtls_pkg::RspDataBits-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dtls_pkg::CsrIndexBits-1:0]     csr_index,
   input  logic [dtls_pkg::CsrDataBits-1:0]      csr_wdata
);

   // input register
   logic                               in_valid_ff;
   dtls_pkg::item_kind_type            in_kind_ff;
   logic [4:0]                         in_mode_ff;
   logic                               in_armed_ff;
   logic signed [dtls_pkg::AltBits-1:0] in_alt_ff;
   logic [3:0]                         in_fix_ff;
   logic [15:0]                        in_hacc_ff;
   logic [dtls_pkg::TimeBits-1:0]      in_now_ff;
   logic                               in_ready_ff;
   logic [1:0]                         in_box_ff;

   // configuration
   logic [dtls_pkg::TimeoutUsBits-1:0] timeout_us_ff;
   logic [15:0]                        hacc_max_ff;
   logic                               auto_arm_ff;
   logic [dtls_pkg::AltCfgBits-1:0]    takeoff_alt_ff;
   logic [dtls_pkg::AltCfgBits-1:0]    land_alt_ff;

   // mission state
   dtls_pkg::mission_state_type        state_ff, state_in;
   logic                               wait_valid_ff, wait_valid_in;
   logic [dtls_pkg::TimeBits-1:0]      wait_start_ff, wait_start_in;
   logic [1:0]                         box_ff, box_in;

   // result register
   logic                               rsp_valid_ff;
   dtls_pkg::mission_state_type        rsp_code_ff;
   logic                               rsp_mode_valid_ff, rsp_mode_valid_in;
   logic [4:0]                         rsp_mode_ff, rsp_mode_in;
   logic                               rsp_arm_ff, rsp_arm_in;

   logic                               out_load;
   logic                               in_take;
   logic [dtls_pkg::TimeBits-1:0]      elapsed;
   logic                               timed_out;
   logic                               gps_good;
   logic                               alt_ge_takeoff;
   logic                               alt_le_land;
   logic                               mode_auto_rtl;

   assign out_load   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_take    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (in_take) begin
         in_kind_ff  <= dtls_pkg::item_kind_type'(req_tuser);
         in_mode_ff  <= req_tdata[4:0];
         in_armed_ff <= req_tdata[5];
         in_alt_ff   <= $signed(req_tdata[29:6]);
         in_fix_ff   <= req_tdata[33:30];
         in_hacc_ff  <= req_tdata[49:34];
         in_now_ff   <= req_tdata[97:50];
         in_ready_ff <= req_tdata[98];
         in_box_ff   <= req_tdata[100:99];
      end
   end

   // Scale the timeout to microseconds once, on write
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_us_ff  <= dtls_pkg::TimeoutUsReset;
         hacc_max_ff    <= dtls_pkg::HaccMaxReset;
         auto_arm_ff    <= 1'b0;
         takeoff_alt_ff <= dtls_pkg::TakeoffAltReset;
         land_alt_ff    <= dtls_pkg::LandAltReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            dtls_pkg::REG_GPS_TIMEOUT: begin
               timeout_us_ff <= dtls_pkg::TimeoutUsBits'(csr_wdata[15:0])
                              * dtls_pkg::TimeoutUsBits'(dtls_pkg::UsPerSec);
            end
            dtls_pkg::REG_GPS_HACC_MAX: hacc_max_ff    <= csr_wdata[15:0];
            dtls_pkg::REG_AUTO_ARM:     auto_arm_ff    <= csr_wdata[0];
            dtls_pkg::REG_TAKEOFF_ALT:  takeoff_alt_ff <= csr_wdata;
            dtls_pkg::REG_LAND_ALT:     land_alt_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign elapsed        = in_now_ff - wait_start_ff;
   assign timed_out      = 64'(elapsed) >= 64'(timeout_us_ff);
   assign gps_good       = (in_fix_ff == dtls_pkg::FIX_RTK) && (in_hacc_ff <= hacc_max_ff);
   assign alt_ge_takeoff = in_alt_ff >= $signed({7'b0, takeoff_alt_ff});
   assign alt_le_land    = in_alt_ff <= $signed({7'b0, land_alt_ff});
   assign mode_auto_rtl  = (in_mode_ff == dtls_pkg::MODE_AUTO)
                        || (in_mode_ff == dtls_pkg::MODE_RTL);

   always_comb begin
      dtls_pkg::mission_state_type tick_state;
      tick_state        = state_ff;
      state_in          = state_ff;
      wait_valid_in     = wait_valid_ff;
      wait_start_in     = wait_start_ff;
      box_in            = box_ff;
      rsp_mode_valid_in = 1'b0;
      rsp_mode_in       = dtls_pkg::MODE_NONE;
      rsp_arm_in        = 1'b0;
      unique case (in_kind_ff)
         dtls_pkg::KIND_TAKEOFF_READY: begin
            if (in_ready_ff && state_ff == dtls_pkg::ST_TO_REQ)
               state_in = dtls_pkg::ST_TO_READY;
         end
         dtls_pkg::KIND_LANDING_READY: begin
            if (in_ready_ff && state_ff == dtls_pkg::ST_LD_REQ)
               state_in = dtls_pkg::ST_LANDING;
         end
         dtls_pkg::KIND_BOX_STATE: begin
            box_in = in_box_ff;
         end
         default: begin
            // mode override, then carry on from the forced state
            if (in_mode_ff == dtls_pkg::MODE_STABILIZE)
               tick_state = dtls_pkg::ST_RECOVER;
            else if (in_mode_ff == dtls_pkg::MODE_ALT_HOLD)
               tick_state = dtls_pkg::ST_STANDBY;
            state_in = tick_state;
            unique case (tick_state)
               dtls_pkg::ST_STANDBY: begin
                  if (in_mode_ff == dtls_pkg::MODE_LOITER)
                     state_in = dtls_pkg::ST_TO_REQ;
               end
               dtls_pkg::ST_TO_READY: begin
                  if (!gps_good) begin
                     if (!wait_valid_ff) begin
                        wait_start_in = in_now_ff;
                        wait_valid_in = 1'b1;
                     end else if (timed_out) begin
                        state_in = dtls_pkg::ST_RECOVER;
                     end
                  end else begin
                     wait_valid_in = 1'b0;
                     wait_start_in = '0;
                     if (in_mode_ff == dtls_pkg::MODE_LOITER && auto_arm_ff)
                        rsp_arm_in = 1'b1;
                     if (in_armed_ff) begin
                        rsp_mode_valid_in = 1'b1;
                        rsp_mode_in       = dtls_pkg::MODE_AUTO;
                        if (alt_ge_takeoff)
                           state_in = dtls_pkg::ST_AIRBORNE;
                     end
                  end
               end
               dtls_pkg::ST_AIRBORNE: begin
                  if (box_ff == dtls_pkg::BOX_AIRBORNE && mode_auto_rtl && alt_le_land)
                     state_in = dtls_pkg::ST_LD_REQ;
               end
               dtls_pkg::ST_LD_REQ: begin
                  if (mode_auto_rtl) begin
                     rsp_mode_valid_in = 1'b1;
                     rsp_mode_in       = dtls_pkg::MODE_GUIDED;
                  end
               end
               dtls_pkg::ST_LANDING: begin
                  if (in_mode_ff == dtls_pkg::MODE_GUIDED) begin
                     rsp_mode_valid_in = 1'b1;
                     rsp_mode_in       = dtls_pkg::MODE_LAND;
                  end
                  if (!in_armed_ff)
                     state_in = dtls_pkg::ST_TOUCHDOWN;
               end
               dtls_pkg::ST_TOUCHDOWN: begin
                  if (!in_armed_ff)
                     state_in = dtls_pkg::ST_LANDED;
               end
               dtls_pkg::ST_LANDED: begin
                  if (box_ff == dtls_pkg::BOX_LANDED || box_ff == dtls_pkg::BOX_STANDBY)
                     state_in = dtls_pkg::ST_STANDBY;
               end
               default: ;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtls_pkg::ST_STANDBY;
         wait_valid_ff <= 1'b0;
         wait_start_ff <= '0;
         box_ff        <= dtls_pkg::BOX_OTHER;
      end else if (out_load) begin
         state_ff      <= state_in;
         wait_valid_ff <= wait_valid_in;
         wait_start_ff <= wait_start_in;
         box_ff        <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_code_ff       <= state_in;
         rsp_mode_valid_ff <= rsp_mode_valid_in;
         rsp_mode_ff       <= rsp_mode_in;
         rsp_arm_ff        <= rsp_arm_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_arm_ff, rsp_mode_ff, rsp_mode_valid_ff, rsp_code_ff};

   // hold a captured item while the result side is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(in_now_ff) && $stable(in_kind_ff))
      else $error("input register lost or changed a stalled item");

   a_arm_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_arm_ff |->
         rsp_code_ff == dtls_pkg::ST_TO_READY || rsp_code_ff == dtls_pkg::ST_AIRBORNE)
      else $error("arm request outside takeoff");

   a_land_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mode_valid_ff && rsp_mode_ff == dtls_pkg::MODE_LAND |->
         rsp_code_ff == dtls_pkg::ST_LANDING || rsp_code_ff == dtls_pkg::ST_TOUCHDOWN)
      else $error("land mode requested outside landing");

   a_mode_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_mode_valid_ff |-> rsp_mode_ff == dtls_pkg::MODE_NONE)
      else $error("mode code present without a mode request");

   a_state_follows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> state_ff == rsp_code_ff)
      else $error("reported mission code differs from stored state");

endmodule
